// ----- rtl/core/lrt_pkg.sv -----
// shared types, constants and table-building functions for the logistic regression trainer
`timescale 1ns / 1ps

package lrt_pkg;

    // fixed field widths
    localparam int FEAT_W   = 16;
    localparam int WEIGHT_W = 32;
    localparam int PROB_W   = 16;
    localparam int NL_W     = 20;
    localparam int ERR_W    = 18;
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 18;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 88;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EPOCHS    = 2'd2;

    // register reset values
    localparam logic [3:0]  DIMS_RESET   = 4'd15;
    localparam logic [15:0] RATE_RESET   = 16'd6554;
    localparam logic [15:0] EPOCHS_RESET = 16'd65535;

    // probability limits in Q0.16
    localparam logic [63:0] P_MIN = 64'd7;
    localparam logic [63:0] P_MAX = 64'd65529;
    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

    // one sigmoid table entry
    typedef struct packed {
        logic [NL_W-1:0]   nl_neg;
        logic [NL_W-1:0]   nl_pos;
        logic [PROB_W-1:0] prob;
    } t_sig_entry;

    // sequencer states
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_EPOCH,
        ST_SAMPLE,
        ST_FRD,
        ST_FMUL,
        ST_FACC,
        ST_INDEX,
        ST_LOOKUP,
        ST_ERROR,
        ST_GMUL,
        ST_GACC,
        ST_NEXT,
        ST_CDIV,
        ST_CWAIT,
        ST_GDIV,
        ST_GWAIT,
        ST_UMUL,
        ST_UPDATE,
        ST_CHECK,
        ST_EMIT
    } t_state;

    // elaboration-time long division
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // logistic probability at a bin centre, Q0.16, clamped
    function automatic logic [63:0] prob_at(input logic signed [63:0] zc);
        logic [63:0] a;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] den;
        logic [63:0] p;
        a = (zc < 0) ? 64'(-zc) : 64'(zc);
        t = a << 12;
        s = ONE_Q32;
        for (int k = 8; k >= 1; k--) begin
            s = ONE_Q32 - udiv64((t * s) >> 32, 64'(k));
        end
        for (int k = 0; k < 4; k++) begin
            if (s > 64'hFFFF_FFFF) begin
                s = 64'hFFFF_FFFF;
            end
            s = (s * s) >> 32;
        end
        den = ONE_Q32 + s;
        p = udiv64((64'd1 << 48) + (den >> 1), den);
        if (zc < 0) begin
            p = 64'd65536 - p;
        end
        if (p < P_MIN) begin
            p = P_MIN;
        end
        if (p > P_MAX) begin
            p = P_MAX;
        end
        return p;
    endfunction

    // -ln(q / 65536) in Q16.16 via binary log2
    function automatic logic [31:0] neg_ln(input logic [63:0] q);
        int unsigned n;
        logic [63:0] x;
        logic [63:0] frac;
        logic [63:0] l2;
        n = 0;
        while (n < 15 && (q >> (n + 1)) != 64'd0) begin
            n++;
        end
        x = q << (30 - n);
        frac = '0;
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= 64'h8000_0000) begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        l2 = (64'd16 << 16) - ((64'(n) << 16) + frac);
        return 32'((l2 * 64'd45426 + 64'd32768) >> 16);
    endfunction

    // full table entry for bin i of depth bins over [-8, 8)
    function automatic t_sig_entry sig_entry(input int unsigned i, input int unsigned depth);
        logic [63:0] off;
        logic signed [63:0] zc;
        logic [63:0] p;
        logic [31:0] lp;
        logic [31:0] ln;
        t_sig_entry e;
        off = udiv64((64'(2 * i + 1)) << 19, 64'(depth));
        zc  = $signed(off) - 64'sd524288;
        p   = prob_at(zc);
        lp  = neg_ln(p);
        ln  = neg_ln(64'd65536 - p);
        e.prob   = p[PROB_W-1:0];
        e.nl_pos = lp[NL_W-1:0];
        e.nl_neg = ln[NL_W-1:0];
        return e;
    endfunction

endpackage

// ----- rtl/core/lrt_mul.sv -----
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module lrt_mul (
    input  logic                                i_clk,
    input  logic signed [lrt_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [lrt_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [lrt_pkg::MUL_P_W-1:0]  o_p
);

    logic signed [lrt_pkg::MUL_P_W-1:0] r_p;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_p <= lrt_pkg::MUL_P_W'(i_a) * lrt_pkg::MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/lrt_divider.sv -----
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lrt_divider #(
    parameter int NW = 43,
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;
    logic [DW:0]      trial;
    logic             fits;

    // trial subtract of the next partial remainder
    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        fits  = (trial >= {1'b0, r_div});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], fits};
            r_rem <= fits ? DW'(trial - {1'b0, r_div}) : DW'(trial);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/lrt_sigmoid_rom.sv -----
// sigmoid and log-cost lookup table with registered read
`timescale 1ns / 1ps

module lrt_sigmoid_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic [$clog2(DEPTH)-1:0]    i_addr,
    output lrt_pkg::t_sig_entry         o_data
);

    lrt_pkg::t_sig_entry tab [DEPTH];
    lrt_pkg::t_sig_entry r_data;

    // table contents worked out at elaboration
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_tab
        localparam lrt_pkg::t_sig_entry ENTRY = lrt_pkg::sig_entry(gi, DEPTH);
        assign tab[gi] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        r_data <= tab[i_addr];
    end

    assign o_data = r_data;

endmodule

// ----- rtl/core/lrt_sample_store.sv -----
// feature memory and per-sample length and label memory
`timescale 1ns / 1ps

module lrt_sample_store #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_DIMS    = 15,
    localparam int FTOT    = MAX_SAMPLES * MAX_DIMS,
    localparam int FADDR_W = (FTOT > 1) ? $clog2(FTOT) : 1,
    localparam int SADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int LEN_W   = $clog2(MAX_DIMS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_feat_we,
    input  logic [FADDR_W-1:0]          i_feat_waddr,
    input  logic [lrt_pkg::FEAT_W-1:0]  i_feat_wdata,
    input  logic [FADDR_W-1:0]          i_feat_raddr,
    output logic [lrt_pkg::FEAT_W-1:0]  o_feat_rdata,
    input  logic                        i_info_we,
    input  logic [SADDR_W-1:0]          i_info_waddr,
    input  logic [LEN_W-1:0]            i_info_wlen,
    input  logic                        i_info_wlabel,
    input  logic [SADDR_W-1:0]          i_info_raddr,
    output logic [LEN_W-1:0]            o_info_len,
    output logic                        o_info_label
);

    logic [lrt_pkg::FEAT_W-1:0] feat_mem [FTOT];
    logic [LEN_W:0]             info_mem [MAX_SAMPLES];
    logic [lrt_pkg::FEAT_W-1:0] r_feat_rdata;
    logic [LEN_W:0]             r_info_rdata;

    // feature memory
    always_ff @(posedge i_clk) begin
        if (i_feat_we) begin
            feat_mem[i_feat_waddr] <= i_feat_wdata;
        end
        r_feat_rdata <= feat_mem[i_feat_raddr];
    end

    // sample length and label memory
    always_ff @(posedge i_clk) begin
        if (i_info_we) begin
            info_mem[i_info_waddr] <= {i_info_wlen, i_info_wlabel};
        end
        r_info_rdata <= info_mem[i_info_raddr];
    end

    assign o_feat_rdata = r_feat_rdata;
    assign o_info_len   = r_info_rdata[LEN_W:1];
    assign o_info_label = r_info_rdata[0];

endmodule

// ----- rtl/core/logistic_regression_trainer_unit.sv -----
// logistic regression trainer: sample loading, gradient-descent sequencer and weight output
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata: feature, label; tlast: end of sample;
//                                                 tuser: end of set
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: index, weight, cost, epochs;
//                                                 tlast: last weight; tuser: set overflow
//   cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// loading takes one feature per cycle. after end of set the block is not ready while it trains;
// each epoch is paced by the single multiplier and the bit-serial divider, whose quotient width
// G is 32 + width of the sample count.
// the d+1 weights then leave one per cycle as the sink takes them; tready low holds the item.
// reset is synchronous and clears control state and configuration; no clearing pass is needed.
`timescale 1ns / 1ps

module logistic_regression_trainer_unit #(
    parameter int MAX_SAMPLES         = 1024,
    parameter int MAX_DIMS            = 15,
    parameter int SIGMOID_TABLE_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lrt_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // feature_value[15:0], label[16]
    input  logic                                 s_axis_tlast,  // end_of_sample
    input  logic                                 s_axis_tuser,  // end_of_set
    // weight stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // weight_index[3:0], weight_value[35:4], final_cost[67:36], epochs_run[83:68]
    output logic [lrt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,  // last
    output logic                                 m_axis_tuser,  // set_overflow
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lrt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lrt_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int SCNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int FTOT    = MAX_SAMPLES * MAX_DIMS;
    localparam int FADDR_W = (FTOT > 1) ? $clog2(FTOT) : 1;
    localparam int FBASE_W = $clog2(FTOT + 1);
    localparam int NW      = MAX_DIMS + 1;
    localparam int J_W     = $clog2(NW);
    localparam int IDX_W   = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int GW      = 32 + SCNT_W;
    localparam int CSW     = lrt_pkg::NL_W + SCNT_W;
    localparam int ZW      = 48 + J_W;
    localparam int ZQW     = ZW - 8;
    localparam int PREV_W  = lrt_pkg::NL_W + 1;

    localparam logic [J_W-1:0]     DIMS_CAP   = J_W'(MAX_DIMS);
    localparam logic [SCNT_W-1:0]  SAMPLE_CAP = SCNT_W'(MAX_SAMPLES);
    localparam logic [FBASE_W-1:0] FSTEP      = FBASE_W'(MAX_DIMS);
    localparam logic signed [ZQW-1:0] Z_LOW   = -ZQW'(524288);
    localparam logic signed [ZQW-1:0] Z_HIGH  = ZQW'(524287);
    localparam logic [39:0]        TAB_SCALE  = 40'(SIGMOID_TABLE_DEPTH);

    // configuration
    logic [3:0]  r_dims;
    logic [15:0] r_rate;
    logic [15:0] r_max;

    // sequencer and loading state
    lrt_pkg::t_state r_state, n_state;
    logic [J_W-1:0]     r_pos;
    logic [SCNT_W-1:0]  r_count;
    logic [FBASE_W-1:0] r_lbase;
    logic               r_ovf;

    // training state
    logic [SCNT_W-1:0]  r_s;
    logic [FBASE_W-1:0] r_base;
    logic [J_W-1:0]     r_j;
    logic signed [ZW-1:0] r_z;
    logic [IDX_W-1:0]   r_idx;
    logic signed [lrt_pkg::ERR_W-1:0] r_err;
    logic [CSW-1:0]     r_cost;
    logic [lrt_pkg::NL_W-1:0] r_cur;
    logic [PREV_W-1:0]  r_prev;
    logic [15:0]        r_ecnt;
    logic               r_gneg;
    logic signed [31:0] r_g;
    logic signed [lrt_pkg::WEIGHT_W-1:0] r_w [NW];
    logic signed [GW-1:0] r_grad [NW];
    logic signed [lrt_pkg::FEAT_W-1:0] r_x [NW];

    // combinational control
    logic in_acc, out_acc, cfg_acc;
    logic eos, eset;
    logic [J_W-1:0] d_eff;
    logic feat_we, info_we;
    logic [FADDR_W-1:0] feat_waddr, feat_raddr;
    logic [J_W-1:0] wlen;
    logic [lrt_pkg::FEAT_W-1:0] feat_rdata;
    logic [J_W-1:0] info_len;
    logic info_label;
    logic signed [lrt_pkg::FEAT_W-1:0] x_masked;
    logic signed [lrt_pkg::MUL_A_W-1:0] mul_a;
    logic signed [lrt_pkg::MUL_B_W-1:0] mul_b;
    logic signed [lrt_pkg::MUL_P_W-1:0] mul_p;
    logic div_start, div_done;
    logic [GW-1:0] div_dividend, div_q;
    logic [GW-1:0] gmag;
    logic signed [ZQW-1:0] zq;
    logic [19:0] zoff;
    logic [39:0] zscaled;
    lrt_pkg::t_sig_entry rom_q;
    logic signed [lrt_pkg::MUL_P_W-1:0] delta_full;
    logic signed [33:0] wdiff;
    logic signed [31:0] wsat;
    logic [31:0] gq;
    logic keep_going;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign eos     = s_axis_tlast;
    assign eset    = s_axis_tuser;
    assign o_cfg_ready = 1'b1;

    // dimensions in use, capped to capacity
    assign d_eff = (r_dims > 4'(MAX_DIMS)) ? DIMS_CAP : J_W'(r_dims);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= lrt_pkg::DIMS_RESET;
            r_rate <= lrt_pkg::RATE_RESET;
            r_max  <= lrt_pkg::EPOCHS_RESET;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                lrt_pkg::CFG_DIMS_IN_USE:   r_dims <= i_cfg_data[3:0];
                lrt_pkg::CFG_LEARNING_RATE: r_rate <= i_cfg_data;
                lrt_pkg::CFG_MAX_EPOCHS:    r_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared units
    lrt_sample_store #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_DIMS    (MAX_DIMS)
    ) u_store (
        .i_clk         (i_clk),
        .i_feat_we     (feat_we),
        .i_feat_waddr  (feat_waddr),
        .i_feat_wdata  (s_axis_tdata[lrt_pkg::FEAT_W-1:0]),
        .i_feat_raddr  (feat_raddr),
        .o_feat_rdata  (feat_rdata),
        .i_info_we     (info_we),
        .i_info_waddr  (r_count[SADDR_W-1:0]),
        .i_info_wlen   (wlen),
        .i_info_wlabel (s_axis_tdata[lrt_pkg::FEAT_W]),
        .i_info_raddr  (r_s[SADDR_W-1:0]),
        .o_info_len    (info_len),
        .o_info_label  (info_label)
    );

    lrt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    lrt_divider #(
        .NW (GW),
        .DW (SCNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    lrt_sigmoid_rom #(
        .DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_idx),
        .o_data (rom_q)
    );

    // datapath helpers
    always_comb begin
        x_masked = (r_j <= info_len) ? $signed(feat_rdata) : '0;
        gmag = r_grad[r_j][GW-1] ? GW'(-r_grad[r_j]) : GW'(r_grad[r_j]);
        zq = $signed(r_z[ZW-1:8]);
        if (zq < Z_LOW) begin
            zoff = 20'd0;
        end else if (zq > Z_HIGH) begin
            zoff = 20'hFFFFF;
        end else begin
            zoff = {~zq[19], zq[18:0]};
        end
        zscaled = 40'(zoff) * TAB_SCALE;
        delta_full = mul_p >>> 24;
        wdiff = 34'(r_w[r_j]) - 34'(delta_full);
        if (wdiff > 34'sh0_7FFF_FFFF) begin
            wsat = 32'sh7FFF_FFFF;
        end else if (wdiff < -34'sh0_8000_0000) begin
            wsat = -32'sh8000_0000;
        end else begin
            wsat = wdiff[31:0];
        end
        gq = div_q[31:0];
        keep_going = ({1'b0, r_cur} < r_prev) && ((17'(r_ecnt) + 17'd1) < 17'(r_max));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrt_pkg::ST_LOAD:   if (in_acc && eset) n_state = lrt_pkg::ST_EPOCH;
            lrt_pkg::ST_EPOCH:  n_state = lrt_pkg::ST_SAMPLE;
            lrt_pkg::ST_SAMPLE: n_state = (d_eff == '0) ? lrt_pkg::ST_INDEX : lrt_pkg::ST_FRD;
            lrt_pkg::ST_FRD:    n_state = lrt_pkg::ST_FMUL;
            lrt_pkg::ST_FMUL:   n_state = lrt_pkg::ST_FACC;
            lrt_pkg::ST_FACC:   n_state = (r_j == d_eff) ? lrt_pkg::ST_INDEX : lrt_pkg::ST_FRD;
            lrt_pkg::ST_INDEX:  n_state = lrt_pkg::ST_LOOKUP;
            lrt_pkg::ST_LOOKUP: n_state = lrt_pkg::ST_ERROR;
            lrt_pkg::ST_ERROR:  n_state = lrt_pkg::ST_GMUL;
            lrt_pkg::ST_GMUL:   n_state = lrt_pkg::ST_GACC;
            lrt_pkg::ST_GACC:   n_state = (r_j == d_eff) ? lrt_pkg::ST_NEXT : lrt_pkg::ST_GMUL;
            lrt_pkg::ST_NEXT:   begin
                n_state = ((r_s + 1'b1) == r_count) ? lrt_pkg::ST_CDIV : lrt_pkg::ST_SAMPLE;
            end
            lrt_pkg::ST_CDIV:   n_state = lrt_pkg::ST_CWAIT;
            lrt_pkg::ST_CWAIT:  if (div_done) n_state = lrt_pkg::ST_GDIV;
            lrt_pkg::ST_GDIV:   n_state = lrt_pkg::ST_GWAIT;
            lrt_pkg::ST_GWAIT:  if (div_done) n_state = lrt_pkg::ST_UMUL;
            lrt_pkg::ST_UMUL:   n_state = lrt_pkg::ST_UPDATE;
            lrt_pkg::ST_UPDATE: n_state = (r_j == d_eff) ? lrt_pkg::ST_CHECK : lrt_pkg::ST_GDIV;
            lrt_pkg::ST_CHECK:  n_state = keep_going ? lrt_pkg::ST_EPOCH : lrt_pkg::ST_EMIT;
            lrt_pkg::ST_EMIT:   if (out_acc && r_j == d_eff) n_state = lrt_pkg::ST_LOAD;
            default:            n_state = lrt_pkg::ST_LOAD;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = (r_state == lrt_pkg::ST_LOAD);
        m_axis_tvalid = (r_state == lrt_pkg::ST_EMIT);
        feat_we    = in_acc && (r_pos < DIMS_CAP) && (r_count < SAMPLE_CAP);
        info_we    = in_acc && (eos || eset) && (r_count < SAMPLE_CAP);
        feat_waddr = FADDR_W'(r_lbase + FBASE_W'(r_pos));
        feat_raddr = FADDR_W'(r_base + FBASE_W'(r_j) - 1'b1);
        wlen       = (r_pos < DIMS_CAP) ? r_pos + 1'b1 : DIMS_CAP;
        mul_a = '0;
        mul_b = '0;
        div_start = 1'b0;
        div_dividend = '0;
        case (r_state)
            lrt_pkg::ST_FMUL: begin
                mul_a = r_w[r_j];
                mul_b = lrt_pkg::MUL_B_W'(x_masked);
            end
            lrt_pkg::ST_GMUL: begin
                mul_a = lrt_pkg::MUL_A_W'(r_err);
                mul_b = lrt_pkg::MUL_B_W'(r_x[r_j]);
            end
            lrt_pkg::ST_UMUL: begin
                mul_a = r_g;
                mul_b = {2'b00, r_rate};
            end
            lrt_pkg::ST_CDIV: begin
                div_start = 1'b1;
                div_dividend = GW'(r_cost);
            end
            lrt_pkg::ST_GDIV: begin
                div_start = 1'b1;
                div_dividend = gmag;
            end
            default: ;
        endcase
    end

    // state and loading control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrt_pkg::ST_LOAD;
            r_pos   <= '0;
            r_count <= '0;
            r_lbase <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                if (r_pos < DIMS_CAP) begin
                    r_pos <= r_pos + 1'b1;
                end
                if (eos || eset) begin
                    r_pos <= '0;
                    if (r_count < SAMPLE_CAP) begin
                        r_count <= r_count + 1'b1;
                        r_lbase <= r_lbase + FSTEP;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            // run finished: start a fresh set
            if (r_state == lrt_pkg::ST_EMIT && out_acc && r_j == d_eff) begin
                r_count <= '0;
                r_lbase <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // training datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            lrt_pkg::ST_LOAD: begin
                if (in_acc && eset) begin
                    for (int k = 0; k < NW; k++) begin
                        r_w[k] <= '0;
                    end
                    r_ecnt <= '0;
                    r_prev <= '1;
                end
            end
            lrt_pkg::ST_EPOCH: begin
                for (int k = 0; k < NW; k++) begin
                    r_grad[k] <= '0;
                end
                r_cost <= '0;
                r_s    <= '0;
                r_base <= '0;
            end
            lrt_pkg::ST_SAMPLE: begin
                r_z    <= {{(ZW - 40){r_w[0][31]}}, r_w[0], 8'd0};
                r_x[0] <= 16'sd256;
                r_j    <= J_W'(1);
            end
            lrt_pkg::ST_FMUL: begin
                r_x[r_j] <= x_masked;
            end
            lrt_pkg::ST_FACC: begin
                r_z <= r_z + ZW'(mul_p);
                if (r_j != d_eff) begin
                    r_j <= r_j + 1'b1;
                end
            end
            lrt_pkg::ST_INDEX: begin
                r_idx <= zscaled[20 + IDX_W - 1:20];
            end
            lrt_pkg::ST_ERROR: begin
                r_cost <= r_cost + CSW'(info_label ? rom_q.nl_pos : rom_q.nl_neg);
                r_err  <= info_label ?
                    lrt_pkg::ERR_W'({2'b00, rom_q.prob} - 18'd65536) :
                    lrt_pkg::ERR_W'({2'b00, rom_q.prob});
                r_j <= '0;
            end
            lrt_pkg::ST_GACC: begin
                r_grad[r_j] <= r_grad[r_j] + GW'(mul_p);
                if (r_j != d_eff) begin
                    r_j <= r_j + 1'b1;
                end
            end
            lrt_pkg::ST_NEXT: begin
                r_s    <= r_s + 1'b1;
                r_base <= r_base + FSTEP;
            end
            lrt_pkg::ST_CWAIT: begin
                if (div_done) begin
                    r_cur <= div_q[lrt_pkg::NL_W-1:0];
                    r_j   <= '0;
                end
            end
            lrt_pkg::ST_GDIV: begin
                r_gneg <= r_grad[r_j][GW-1];
            end
            lrt_pkg::ST_GWAIT: begin
                if (div_done) begin
                    r_g <= r_gneg ? -$signed(gq) : $signed(gq);
                end
            end
            lrt_pkg::ST_UPDATE: begin
                r_w[r_j] <= wsat;
                if (r_j != d_eff) begin
                    r_j <= r_j + 1'b1;
                end
            end
            lrt_pkg::ST_CHECK: begin
                r_ecnt <= r_ecnt + 1'b1;
                r_prev <= {1'b0, r_cur};
                r_j    <= '0;
            end
            lrt_pkg::ST_EMIT: begin
                if (out_acc && r_j != d_eff) begin
                    r_j <= r_j + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // result item
    assign m_axis_tdata = {4'd0, r_ecnt, 32'(r_cur), r_w[r_j], 4'(r_j)};
    assign m_axis_tlast = (r_j == d_eff);
    assign m_axis_tuser = r_ovf;

endmodule
